[sv/ddf_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// ddf_pkg
// Shared types, constants and decode functions for the dictionary record
// field deframer.
// ============================================================================
package ddf_pkg;

    localparam int SEQ_MAX_DEFAULT = 8;
    localparam int SEQ_POS_W       = 4;
    localparam int TYPE_SEQ_W      = 64;
    localparam int SEQ_LEN_W       = 4;

    localparam logic CFG_TYPE_SEQUENCE   = 1'b0;
    localparam logic CFG_SEQUENCE_LENGTH = 1'b1;

    localparam logic [3:0] CAT_MEANING  = 4'd0;
    localparam logic [3:0] CAT_PHONETIC = 4'd1;
    localparam logic [3:0] CAT_OTHER    = 4'd2;
    localparam logic [3:0] CAT_IMAGE    = 4'd3;
    localparam logic [3:0] CAT_SOUND    = 4'd4;
    localparam logic [3:0] CAT_VIDEO    = 4'd5;
    localparam logic [3:0] CAT_WAVE     = 4'd6;
    localparam logic [3:0] CAT_PICTURE  = 4'd7;
    localparam logic [3:0] CAT_FRAMING  = 4'd8;
    localparam logic [3:0] CAT_IGNORED  = 4'd9;
    localparam logic [3:0] CAT_INVALID  = 4'd15;

    localparam logic [7:0] TYPE_TEXT_M   = "m";
    localparam logic [7:0] TYPE_TEXT_L   = "l";
    localparam logic [7:0] TYPE_TEXT_G   = "g";
    localparam logic [7:0] TYPE_TEXT_T   = "t";
    localparam logic [7:0] TYPE_TEXT_Y   = "y";
    localparam logic [7:0] TYPE_TEXT_X   = "x";
    localparam logic [7:0] TYPE_TEXT_K   = "k";
    localparam logic [7:0] TYPE_TEXT_W   = "w";
    localparam logic [7:0] TYPE_TEXT_H   = "h";
    localparam logic [7:0] TYPE_RESOURCE = "r";
    localparam logic [7:0] TYPE_WAVE     = "W";
    localparam logic [7:0] TYPE_PICTURE  = "P";

    localparam logic [23:0] PFX_IMG = "img";
    localparam logic [23:0] PFX_SND = "snd";
    localparam logic [23:0] PFX_VDO = "vdo";
    localparam logic [23:0] PFX_ATT = "att";

    typedef enum logic [6:0] {
        PH_AWAIT   = 7'b0000001,
        PH_STRING  = 7'b0000010,
        PH_PREFIX  = 7'b0000100,
        PH_SEP     = 7'b0001000,
        PH_BODY    = 7'b0010000,
        PH_LENGTH  = 7'b0100000,
        PH_PAYLOAD = 7'b1000000
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_of_record;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [3:0] category;
        logic       field_end;
        logic       format_error;
        logic       record_done;
    } result_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_of_record;
        logic       is_zero;
        phase_t     inline_phase;
    } front_item_t;

    typedef struct packed {
        logic full;
        logic not_empty;
    } queue_status_t;

    function automatic logic [3:0] text_category(input logic [7:0] t);
        logic [3:0] c;
        unique case (t)
            TYPE_TEXT_M, TYPE_TEXT_L, TYPE_TEXT_G: c = CAT_MEANING;
            TYPE_TEXT_T, TYPE_TEXT_Y: c = CAT_PHONETIC;
            TYPE_TEXT_X, TYPE_TEXT_K, TYPE_TEXT_W, TYPE_TEXT_H: c = CAT_OTHER;
            default: c = CAT_INVALID;
        endcase
        return c;
    endfunction

    function automatic phase_t start_phase(input logic [7:0] t);
        phase_t p;
        if (text_category(t) != CAT_INVALID) begin
            p = PH_STRING;
        end else if (t == TYPE_RESOURCE) begin
            p = PH_PREFIX;
        end else if (t == TYPE_WAVE || t == TYPE_PICTURE) begin
            p = PH_LENGTH;
        end else begin
            p = PH_AWAIT;
        end
        return p;
    endfunction

    function automatic logic [3:0] resource_category(input logic [23:0] p);
        logic [3:0] c;
        if (p == PFX_IMG) begin
            c = CAT_IMAGE;
        end else if (p == PFX_SND) begin
            c = CAT_SOUND;
        end else if (p == PFX_VDO) begin
            c = CAT_VIDEO;
        end else if (p == PFX_ATT) begin
            c = CAT_OTHER;
        end else begin
            c = CAT_IGNORED;
        end
        return c;
    endfunction

endpackage

[sv/ddf_front.sv]
`timescale 1ns / 1ps
// ============================================================================
// ddf_front
// Accepts input transactions and tags each byte with its stateless
// classification before it enters the queue.
// ============================================================================
module ddf_front
    import ddf_pkg::*;
(
    input  logic          s_valid,
    output logic          s_ready,
    input  in_item_t      s_data,
    input  queue_status_t q_status,
    output logic          push,
    output front_item_t   push_item
);

    assign s_ready = ~q_status.full;
    assign push    = s_valid & s_ready;

    always_comb begin
        push_item.data_byte      = s_data.data_byte;
        push_item.last_of_record = s_data.last_of_record;
        push_item.is_zero        = (s_data.data_byte == 8'd0);
        push_item.inline_phase   = start_phase(s_data.data_byte);
    end

endmodule

[sv/ddf_queue.sv]
`timescale 1ns / 1ps
// ============================================================================
// ddf_queue
// Two-entry queue between the classifying front end and the parser.
// ============================================================================
module ddf_queue
    import ddf_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  front_item_t   push_item,
    input  logic          pop,
    output front_item_t   pop_item,
    output queue_status_t q_status
);

    front_item_t entry_mem [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        do_pop;

    assign do_pop             = pop & (count_reg != 2'd0);
    assign q_status.full      = (count_reg == 2'd2);
    assign q_status.not_empty = (count_reg != 2'd0);
    assign pop_item           = entry_mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[sv/ddf_back.sv]
`timescale 1ns / 1ps
// ============================================================================
// ddf_back
// Field parser: holds the configuration and the parse state, steps one byte
// per cycle unless output stalls, and drives the registered result channel.
// ============================================================================
module ddf_back
    import ddf_pkg::*;
#(
    parameter int SEQ_MAX = SEQ_MAX_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic                  cfg_index,
    input  logic [TYPE_SEQ_W-1:0] cfg_data,
    input  queue_status_t         q_status,
    input  front_item_t           q_item,
    output logic                  pop,
    output logic                  m_valid,
    input  logic                  m_ready,
    output result_t               m_data
);

    logic [TYPE_SEQ_W-1:0] type_seq_reg;
    logic [SEQ_LEN_W-1:0]  seq_len_reg;

    phase_t               phase_reg, phase_next;
    logic [SEQ_POS_W-1:0] pos_reg, pos_next;
    logic [7:0]           type_reg, type_next;
    logic [31:0]          rem_reg, rem_next;
    logic [2:0]           hdr_reg, hdr_next;
    logic [23:0]          pfx_reg, pfx_next;
    logic                 m_valid_reg, m_valid_next;
    result_t              m_data_reg;

    logic [SEQ_POS_W-1:0] n_sat;
    logic                 found;
    logic [SEQ_POS_W-1:0] found_idx;
    logic [7:0]           found_type;
    logic                 done;
    logic [3:0]           cat;
    logic                 fend;
    logic                 err;
    logic [31:0]          rem_dec;
    result_t              result;

    assign cfg_ready = 1'b1;
    assign pop       = q_status.not_empty & (~m_valid_reg | m_ready);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    always_comb begin
        n_sat = (seq_len_reg > SEQ_POS_W'(SEQ_MAX)) ? SEQ_POS_W'(SEQ_MAX) : seq_len_reg;
        found      = 1'b0;
        found_idx  = '0;
        found_type = '0;
        for (int i = SEQ_MAX - 1; i >= 0; i--) begin
            if (SEQ_POS_W'(i) >= pos_reg && SEQ_POS_W'(i) < n_sat &&
                start_phase(type_seq_reg[8*i +: 8]) != PH_AWAIT) begin
                found      = 1'b1;
                found_idx  = SEQ_POS_W'(i);
                found_type = type_seq_reg[8*i +: 8];
            end
        end
    end

    always_comb begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        type_next  = type_reg;
        rem_next   = rem_reg;
        hdr_next   = hdr_reg;
        pfx_next   = pfx_reg;
        done       = 1'b0;
        cat        = CAT_IGNORED;
        fend       = 1'b0;
        err        = 1'b0;
        rem_dec    = rem_reg - 32'd1;

        if (phase_reg == PH_AWAIT) begin
            if (seq_len_reg == '0) begin
                done = 1'b1;
                cat  = CAT_FRAMING;
                if (q_item.inline_phase == PH_AWAIT) begin
                    err = 1'b1;
                end else begin
                    type_next  = q_item.data_byte;
                    phase_next = q_item.inline_phase;
                    rem_next   = '0;
                    hdr_next   = '0;
                    pfx_next   = '0;
                end
            end else if (found) begin
                err        = (found_idx != pos_reg);
                pos_next   = found_idx + SEQ_POS_W'(1);
                type_next  = found_type;
                phase_next = start_phase(found_type);
                rem_next   = '0;
                hdr_next   = '0;
                pfx_next   = '0;
            end else begin
                done = 1'b1;
                cat  = CAT_IGNORED;
                if (pos_reg < n_sat) begin
                    err      = 1'b1;
                    pos_next = n_sat;
                end
            end
        end

        if (!done) begin
            unique case (phase_next)
                PH_STRING: begin
                    cat = text_category(type_next);
                    if (q_item.is_zero) begin
                        fend       = 1'b1;
                        phase_next = PH_AWAIT;
                    end
                end
                PH_PREFIX: begin
                    cat      = CAT_FRAMING;
                    pfx_next = {pfx_next[15:0], q_item.data_byte};
                    hdr_next = hdr_next + 3'd1;
                    if (q_item.is_zero) begin
                        err        = 1'b1;
                        fend       = 1'b1;
                        phase_next = PH_AWAIT;
                    end else if (hdr_next >= 3'd3) begin
                        phase_next = PH_SEP;
                        if (resource_category(pfx_next) == CAT_IGNORED) begin
                            err = 1'b1;
                        end
                    end
                end
                PH_SEP: begin
                    cat        = CAT_FRAMING;
                    phase_next = PH_BODY;
                end
                PH_BODY: begin
                    cat = resource_category(pfx_next);
                    if (q_item.is_zero) begin
                        fend       = 1'b1;
                        phase_next = PH_AWAIT;
                    end
                end
                PH_LENGTH: begin
                    cat      = CAT_FRAMING;
                    rem_next = {rem_next[23:0], q_item.data_byte};
                    hdr_next = hdr_next + 3'd1;
                    if (hdr_next >= 3'd4) begin
                        if (rem_next == 32'd0) begin
                            fend       = 1'b1;
                            phase_next = PH_AWAIT;
                        end else begin
                            phase_next = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    cat      = (type_next == TYPE_WAVE) ? CAT_WAVE : CAT_PICTURE;
                    rem_next = rem_dec;
                    if (rem_dec == 32'd0) begin
                        fend       = 1'b1;
                        phase_next = PH_AWAIT;
                    end
                end
                default: begin
                    cat        = CAT_IGNORED;
                    phase_next = PH_AWAIT;
                end
            endcase
        end

        if (q_item.last_of_record) begin
            if (phase_next != PH_AWAIT) begin
                err = 1'b1;
            end
            phase_next = PH_AWAIT;
            pos_next   = '0;
            type_next  = '0;
            rem_next   = '0;
            hdr_next   = '0;
            pfx_next   = '0;
        end

        result.out_byte     = q_item.data_byte;
        result.category     = cat;
        result.field_end    = fend;
        result.format_error = err;
        result.record_done  = q_item.last_of_record;

        if (pop) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            m_data_reg <= result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            type_seq_reg <= '0;
            seq_len_reg  <= '0;
            phase_reg    <= PH_AWAIT;
            pos_reg      <= '0;
            type_reg     <= '0;
            rem_reg      <= '0;
            hdr_reg      <= '0;
            pfx_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_TYPE_SEQUENCE:   type_seq_reg <= cfg_data;
                    CFG_SEQUENCE_LENGTH: seq_len_reg  <= cfg_data[SEQ_LEN_W-1:0];
                    default:             type_seq_reg <= type_seq_reg;
                endcase
            end
            if (pop) begin
                phase_reg <= phase_next;
                pos_reg   <= pos_next;
                type_reg  <= type_next;
                rem_reg   <= rem_next;
                hdr_reg   <= hdr_next;
                pfx_reg   <= pfx_next;
            end
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

[sv/dictionary_record_field_deframer_top.sv]
`timescale 1ns / 1ps
// Path: accepted input goes into the queue, then the parser writes the result register.
// Throughput: one transaction per cycle, set by the parser, unless the output stalls.
// A two-entry queue and the result register let input and output stall independently.
// Reset (aresetn low, synchronous) clears the configuration, parse state and queue.
// ============================================================================
// dictionary_record_field_deframer_top
// Classifies the bytes of dictionary word records into field categories.
// ============================================================================
module dictionary_record_field_deframer_top
    import ddf_pkg::*;
#(
    parameter int SEQ_MAX = SEQ_MAX_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output result_t               m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic                  cfg_index,
    input  logic [TYPE_SEQ_W-1:0] cfg_data
);

    queue_status_t q_status;
    logic          push;
    front_item_t   push_item;
    logic          pop;
    front_item_t   pop_item;

    ddf_front u_front (
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .q_status  (q_status),
        .push      (push),
        .push_item (push_item)
    );

    ddf_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .q_status  (q_status)
    );

    ddf_back #(
        .SEQ_MAX (SEQ_MAX)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_status  (q_status),
        .q_item    (pop_item),
        .pop       (pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

[sv/ddf_checker.sv]
`timescale 1ns / 1ps
// ============================================================================
// ddf_checker
// Port-level checks on the deframer's result channel and reset behavior.
// ============================================================================
module ddf_checker
    import ddf_pkg::*;
(
    input logic    aclk,
    input logic    aresetn,
    input logic    s_ready,
    input logic    m_valid,
    input logic    m_ready,
    input result_t m_data
);

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("Stalled result transaction changed or dropped.");

    a_category_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.category <= CAT_IGNORED)
        else $error("Result category out of range.");

    a_text_end_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.field_end && m_data.category < CAT_WAVE |->
            m_data.out_byte == 8'd0)
        else $error("Text or resource field closed on a nonzero byte.");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("Block not idle after reset.");

endmodule

bind dictionary_record_field_deframer_top ddf_checker u_ddf_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

[tb/tb.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb
// Self-checking testbench for the dictionary record field deframer. A short
// scripted part covers every field type, the framing corner cases and both
// type modes. Randomized records then run under several register settings.
// Every result transaction is checked against a scripted expectation or a
// behavioral model of the parser, while both channels stall at random.
// ============================================================================
module tb;
    import ddf_pkg::*;

    localparam int SEQ_LIMIT   = SEQ_MAX_DEFAULT;
    localparam int CYCLE_LIMIT = 600000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 210;

    localparam logic [7:0] TYPE_UNKNOWN = "X";

    typedef enum logic {ROW_BYTE, ROW_CONFIG} row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [63:0] types;
        logic [3:0]  count;
        in_item_t    item;
        logic        has_want;
        result_t     want;
    } script_row_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_item_t              s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    result_t               m_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic                  cfg_index = CFG_TYPE_SEQUENCE;
    logic [TYPE_SEQ_W-1:0] cfg_data  = '0;

    logic [63:0] type_list    = '0;
    logic [3:0]  type_count   = '0;
    phase_t      parse_step   = PH_AWAIT;
    logic [3:0]  seq_index    = '0;
    logic [7:0]  field_type   = '0;
    logic [31:0] payload_left = '0;
    logic [2:0]  header_count = '0;
    logic [23:0] prefix_bytes = '0;

    result_t     expected_results[$];
    script_row_t script[$];
    logic [7:0]  pending_bytes[$];

    int unsigned idle_odds   = 0;
    int unsigned sink_hold   = 0;
    int unsigned mismatches  = 0;
    int unsigned cycle_count = 0;

    dictionary_record_field_deframer_top #(
        .SEQ_MAX(SEQ_LIMIT)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 aclk = ~aclk;

    function automatic logic [3:0] text_class(input logic [7:0] t);
        case (t)
            TYPE_TEXT_M, TYPE_TEXT_L, TYPE_TEXT_G: return CAT_MEANING;
            TYPE_TEXT_T, TYPE_TEXT_Y: return CAT_PHONETIC;
            TYPE_TEXT_X, TYPE_TEXT_K, TYPE_TEXT_W, TYPE_TEXT_H: return CAT_OTHER;
            default: return CAT_INVALID;
        endcase
    endfunction

    function automatic phase_t opening_step(input logic [7:0] t);
        if (text_class(t) != CAT_INVALID) return PH_STRING;
        if (t == TYPE_RESOURCE) return PH_PREFIX;
        if (t == TYPE_WAVE || t == TYPE_PICTURE) return PH_LENGTH;
        return PH_AWAIT;
    endfunction

    function automatic logic [3:0] resource_class(input logic [23:0] p);
        case (p)
            PFX_IMG: return CAT_IMAGE;
            PFX_SND: return CAT_SOUND;
            PFX_VDO: return CAT_VIDEO;
            PFX_ATT: return CAT_OTHER;
            default: return CAT_IGNORED;
        endcase
    endfunction

    function automatic void open_field(input logic [7:0] t);
        field_type   = t;
        parse_step   = opening_step(t);
        payload_left = '0;
        header_count = '0;
        prefix_bytes = '0;
    endfunction

    function automatic void clear_parse();
        open_field(8'h00);
        seq_index = '0;
    endfunction

    // Advances the parser state by one record byte and returns its classification.
    function automatic result_t deframe_byte(input in_item_t it);
        result_t    r;
        logic [7:0] b;
        logic [7:0] t;
        int         lim;
        bit         handled;
        b               = it.data_byte;
        r               = '0;
        r.out_byte      = b;
        r.record_done   = it.last_of_record;
        r.category      = CAT_IGNORED;
        handled         = 1'b0;
        if (parse_step == PH_AWAIT) begin
            if (type_count == 0) begin
                r.category = CAT_FRAMING;
                if (opening_step(b) == PH_AWAIT) begin
                    r.format_error = 1'b1;
                end else begin
                    open_field(b);
                end
                handled = 1'b1;
            end else begin
                lim = (type_count > SEQ_LIMIT) ? SEQ_LIMIT : type_count;
                while (seq_index < lim && parse_step == PH_AWAIT) begin
                    t = type_list[8*seq_index +: 8];
                    seq_index = seq_index + 1'b1;
                    if (opening_step(t) == PH_AWAIT) begin
                        r.format_error = 1'b1;
                    end else begin
                        open_field(t);
                    end
                end
                if (parse_step == PH_AWAIT) begin
                    handled = 1'b1;
                end
            end
        end
        if (!handled) begin
            case (parse_step)
                PH_STRING: begin
                    r.category = text_class(field_type);
                    if (b == 8'h00) begin
                        r.field_end = 1'b1;
                        parse_step  = PH_AWAIT;
                    end
                end
                PH_PREFIX: begin
                    r.category   = CAT_FRAMING;
                    prefix_bytes = {prefix_bytes[15:0], b};
                    header_count = header_count + 1'b1;
                    if (b == 8'h00) begin
                        r.format_error = 1'b1;
                        r.field_end    = 1'b1;
                        parse_step     = PH_AWAIT;
                    end else if (header_count >= 3) begin
                        parse_step = PH_SEP;
                        if (resource_class(prefix_bytes) == CAT_IGNORED) begin
                            r.format_error = 1'b1;
                        end
                    end
                end
                PH_SEP: begin
                    r.category = CAT_FRAMING;
                    parse_step = PH_BODY;
                end
                PH_BODY: begin
                    r.category = resource_class(prefix_bytes);
                    if (b == 8'h00) begin
                        r.field_end = 1'b1;
                        parse_step  = PH_AWAIT;
                    end
                end
                PH_LENGTH: begin
                    r.category   = CAT_FRAMING;
                    payload_left = {payload_left[23:0], b};
                    header_count = header_count + 1'b1;
                    if (header_count >= 4) begin
                        if (payload_left == 0) begin
                            r.field_end = 1'b1;
                            parse_step  = PH_AWAIT;
                        end else begin
                            parse_step = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    r.category   = (field_type == TYPE_WAVE) ? CAT_WAVE : CAT_PICTURE;
                    payload_left = payload_left - 1;
                    if (payload_left == 0) begin
                        r.field_end = 1'b1;
                        parse_step  = PH_AWAIT;
                    end
                end
                default: begin
                    r.category = CAT_IGNORED;
                    parse_step = PH_AWAIT;
                end
            endcase
        end
        if (it.last_of_record) begin
            if (parse_step != PH_AWAIT) begin
                r.format_error = 1'b1;
            end
            clear_parse();
        end
        return r;
    endfunction

    function automatic logic [7:0] pick_known_type();
        case ($urandom_range(0, 11))
            0:       return TYPE_TEXT_M;
            1:       return TYPE_TEXT_L;
            2:       return TYPE_TEXT_G;
            3:       return TYPE_TEXT_T;
            4:       return TYPE_TEXT_Y;
            5:       return TYPE_TEXT_X;
            6:       return TYPE_TEXT_K;
            7:       return TYPE_TEXT_W;
            8:       return TYPE_TEXT_H;
            9:       return TYPE_RESOURCE;
            10:      return TYPE_WAVE;
            default: return TYPE_PICTURE;
        endcase
    endfunction

    // Appends the body of one field; returns 1 when the record has to end here.
    function automatic bit append_field(input logic [7:0] t);
        logic [23:0] pfx;
        logic [31:0] len;
        int          n;
        bit          cut;
        cut = 1'b0;
        case (opening_step(t))
            PH_STRING: begin
                repeat ($urandom_range(0, 6)) pending_bytes.push_back(8'($urandom_range(1, 255)));
                pending_bytes.push_back(8'h00);
            end
            PH_PREFIX: begin
                if ($urandom_range(0, 7) == 0) begin
                    pfx = 24'($urandom);
                end else begin
                    case ($urandom_range(0, 3))
                        0:       pfx = PFX_IMG;
                        1:       pfx = PFX_SND;
                        2:       pfx = PFX_VDO;
                        default: pfx = PFX_ATT;
                    endcase
                end
                pending_bytes.push_back(pfx[23:16]);
                pending_bytes.push_back(pfx[15:8]);
                pending_bytes.push_back(pfx[7:0]);
                pending_bytes.push_back(8'($urandom_range(0, 255)));
                repeat ($urandom_range(0, 6)) pending_bytes.push_back(8'($urandom_range(1, 255)));
                pending_bytes.push_back(8'h00);
            end
            PH_LENGTH: begin
                if ($urandom_range(0, 15) == 0) begin
                    len = $urandom;
                    n   = $urandom_range(0, 4);
                    if (len < n) n = len;
                    cut = 1'b1;
                end else begin
                    len = $urandom_range(0, 5);
                    n   = len;
                end
                pending_bytes.push_back(len[31:24]);
                pending_bytes.push_back(len[23:16]);
                pending_bytes.push_back(len[15:8]);
                pending_bytes.push_back(len[7:0]);
                repeat (n) pending_bytes.push_back(8'($urandom_range(0, 255)));
            end
            default: begin
            end
        endcase
        return cut;
    endfunction

    function automatic void build_record();
        int         fields;
        int         lim;
        int         keep;
        logic [7:0] t;
        pending_bytes.delete();
        if ($urandom_range(0, 19) == 0) begin
            repeat ($urandom_range(1, 12)) pending_bytes.push_back(8'($urandom_range(0, 255)));
            return;
        end
        if (type_count == 0) begin
            fields = $urandom_range(1, 4);
            for (int k = 0; k < fields; k++) begin
                t = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : pick_known_type();
                pending_bytes.push_back(t);
                if (append_field(t)) break;
            end
        end else begin
            lim = (type_count > SEQ_LIMIT) ? SEQ_LIMIT : type_count;
            for (int k = 0; k < lim; k++) begin
                if (append_field(type_list[8*k +: 8])) break;
            end
            repeat ($urandom_range(0, 2)) pending_bytes.push_back(8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 9) == 0 && pending_bytes.size() > 1) begin
            keep = $urandom_range(1, pending_bytes.size() - 1);
            while (pending_bytes.size() > keep) void'(pending_bytes.pop_back());
        end
        if (pending_bytes.size() == 0) begin
            pending_bytes.push_back(8'($urandom_range(0, 255)));
        end
    endfunction

    function automatic void add_byte(input logic [7:0] d, input logic last);
        script_row_t row;
        row      = '0;
        row.kind = ROW_BYTE;
        row.item = '{data_byte: d, last_of_record: last};
        script.push_back(row);
    endfunction

    function automatic void add_checked(input logic [7:0] d, input logic last,
                                        input logic [3:0] cat, input logic fend,
                                        input logic err);
        script_row_t row;
        row          = '0;
        row.kind     = ROW_BYTE;
        row.item     = '{data_byte: d, last_of_record: last};
        row.has_want = 1'b1;
        row.want     = '{out_byte: d, category: cat, field_end: fend,
                         format_error: err, record_done: last};
        script.push_back(row);
    endfunction

    function automatic void add_config(input logic [63:0] types, input logic [3:0] count);
        script_row_t row;
        row       = '0;
        row.kind  = ROW_CONFIG;
        row.types = types;
        row.count = count;
        script.push_back(row);
    endfunction

    task automatic wait_drained(input int extra);
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (extra) @(posedge aclk);
    endtask

    task automatic load_config(input logic [63:0] types, input logic [3:0] count);
        wait_drained(4);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_TYPE_SEQUENCE;
        cfg_data  <= types;
        do @(posedge aclk); while (!cfg_ready);
        type_list = types;
        cfg_index <= CFG_SEQUENCE_LENGTH;
        cfg_data  <= {{(TYPE_SEQ_W - SEQ_LEN_W){1'b0}}, count};
        do @(posedge aclk); while (!cfg_ready);
        type_count = count;
        cfg_valid <= 1'b0;
    endtask

    task automatic send_byte(input in_item_t it, input logic use_want, input result_t want,
                             output result_t predicted);
        if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        predicted = deframe_byte(it);
        expected_results.push_back(use_want ? want : predicted);
    endtask

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge aclk) begin
        result_t want;
        if (sink_hold != 0) begin
            sink_hold <= sink_hold - 1;
        end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
            sink_hold <= $urandom_range(0, 15);
            m_ready   <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result transaction, out_byte %0h", m_data.out_byte);
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                if (m_data.out_byte !== want.out_byte) begin
                    $error("out_byte: expected %0h, got %0h", want.out_byte, m_data.out_byte);
                    mismatches++;
                end
                if (m_data.category !== want.category) begin
                    $error("category: expected %0d, got %0d", want.category, m_data.category);
                    mismatches++;
                end
                if (m_data.field_end !== want.field_end) begin
                    $error("field_end: expected %0b, got %0b", want.field_end,
                           m_data.field_end);
                    mismatches++;
                end
                if (m_data.format_error !== want.format_error) begin
                    $error("format_error: expected %0b, got %0b", want.format_error,
                           m_data.format_error);
                    mismatches++;
                end
                if (m_data.record_done !== want.record_done) begin
                    $error("record_done: expected %0b, got %0b", want.record_done,
                           m_data.record_done);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        result_t     predicted;
        in_item_t    item;
        logic [63:0] types;
        logic [3:0]  count;
        int          raw;

        add_checked(TYPE_UNKNOWN, 1'b0, CAT_FRAMING, 1'b0, 1'b1);
        add_byte(TYPE_PICTURE, 1'b0);
        repeat (3) add_byte(8'h00, 1'b0);
        add_checked(8'h00, 1'b0, CAT_FRAMING, 1'b1, 1'b0);
        add_byte(TYPE_WAVE, 1'b0);
        repeat (3) add_byte(8'h00, 1'b0);
        add_byte(8'h01, 1'b0);
        add_checked(8'hAB, 1'b0, CAT_WAVE, 1'b1, 1'b0);
        add_byte(TYPE_RESOURCE, 1'b0);
        repeat (2) add_byte("q", 1'b0);
        add_checked("q", 1'b0, CAT_FRAMING, 1'b0, 1'b1);
        add_byte(8'hFF, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_checked(8'h00, 1'b0, CAT_IGNORED, 1'b1, 1'b0);
        add_byte(TYPE_RESOURCE, 1'b0);
        add_byte("i", 1'b0);
        add_checked(8'h00, 1'b0, CAT_FRAMING, 1'b1, 1'b1);
        add_byte(TYPE_TEXT_T, 1'b0);
        add_checked(8'h80, 1'b1, CAT_PHONETIC, 1'b0, 1'b1);
        add_config({48'd0, TYPE_TEXT_M, TYPE_UNKNOWN}, 4'd2);
        add_byte(8'h41, 1'b0);
        add_byte(8'h00, 1'b0);
        add_checked(8'hFF, 1'b1, CAT_IGNORED, 1'b0, 1'b0);
        add_config('1, 4'd15);
        add_checked(8'h00, 1'b1, CAT_IGNORED, 1'b0, 1'b1);

        idle_odds = 6;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (script[i]) begin
            if (script[i].kind == ROW_CONFIG) begin
                load_config(script[i].types, script[i].count);
            end else begin
                send_byte(script[i].item, script[i].has_want, script[i].want, predicted);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            for (int k = 0; k < 8; k++) begin
                types[8*k +: 8] = ($urandom_range(0, 6) == 0) ? 8'($urandom_range(0, 255))
                                                              : pick_known_type();
            end
            if (p == 0 || $urandom_range(0, 2) == 0) begin
                count = 4'd0;
            end else if ($urandom_range(0, 4) == 0) begin
                count = 4'($urandom_range(9, 15));
            end else begin
                count = 4'($urandom_range(1, 8));
            end
            load_config(types, count);
            idle_odds = (p == PHASES - 1 || $urandom_range(0, 3) == 0) ? 0
                                                                       : $urandom_range(4, 16);
            raw = 0;
            while (raw < PHASE_ITEMS) begin
                build_record();
                foreach (pending_bytes[i]) begin
                    item.data_byte      = pending_bytes[i];
                    item.last_of_record = (i == pending_bytes.size() - 1);
                    send_byte(item, 1'b0, '0, predicted);
                    raw++;
                end
            end
        end

        wait_drained(8);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
